// ===== src/sorted_rate_table_nearest_unit_macros.svh =====
// Assertion macros used by the sorted rate table datapath.
`ifndef SORTED_RATE_TABLE_NEAREST_UNIT_MACROS_SVH
`define SORTED_RATE_TABLE_NEAREST_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define SRTN_CHECK(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srtn: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define SRTN_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srtn: next-cycle check failed");

`endif

// ===== src/srtn_pkg.sv =====
// Shared constants, codes and types of the sorted rate table.
package srtn_pkg;

  localparam int DEPTH     = 16;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int RATE_W    = 20;
  localparam int BYTE_W    = 8;
  localparam int STAT_W    = 2;
  localparam int OUT_IDX_W = 4;
  localparam int OUT_TOT_W = 5;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [RATE_W-1:0]        rate;
    logic [BYTE_W-1:0]        clock;
    logic [BYTE_W-1:0]        prediv;
    logic signed [BYTE_W-1:0] old_prediv;
    logic [BYTE_W-1:0]        gpio;
  } entry_t;

  typedef struct packed {
    logic [STAT_W-1:0]    status;
    logic [OUT_IDX_W-1:0] idx;
    entry_t               entry;
    logic [OUT_TOT_W-1:0] total;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic ins_shift;
    logic ins_put;
    logic srch_adv;
    logic hit_prev;
    logic hit_cur;
    logic res_full;
    logic res_empty;
    logic emit;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic accept;
    logic in_func;
    logic count_zero;
    logic count_full;
    logic ptr_zero;
    logic ptr_last;
    logic rate_gt;
    logic rate_ge_mid;
    logic out_free;
  } dp_status_t;

endpackage

// ===== src/srtn_if.sv =====
// Request and response channel interfaces of the sorted rate table.
interface srtn_req_if;
  logic                               valid;
  logic                               ready;
  logic                               func;
  logic [srtn_pkg::RATE_W-1:0]        rate_hz;
  logic [srtn_pkg::BYTE_W-1:0]        clock_source;
  logic [srtn_pkg::BYTE_W-1:0]        predivider;
  logic signed [srtn_pkg::BYTE_W-1:0] old_predivider;
  logic [srtn_pkg::BYTE_W-1:0]        gpio_value;

  modport source (output valid, func, rate_hz, clock_source, predivider, old_predivider,
                  gpio_value, input ready);
  modport sink (input valid, func, rate_hz, clock_source, predivider, old_predivider,
                gpio_value, output ready);
endinterface

interface srtn_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [srtn_pkg::STAT_W-1:0]         status;
  logic [srtn_pkg::OUT_IDX_W-1:0]      entry_index;
  logic [srtn_pkg::RATE_W-1:0]         found_rate;
  logic [srtn_pkg::BYTE_W-1:0]         found_clock;
  logic [srtn_pkg::BYTE_W-1:0]         found_prediv;
  logic signed [srtn_pkg::BYTE_W-1:0]  found_old_prediv;
  logic [srtn_pkg::BYTE_W-1:0]         found_gpio;
  logic [srtn_pkg::OUT_TOT_W-1:0]      entry_total;

  modport source (output valid, status, entry_index, found_rate, found_clock, found_prediv,
                  found_old_prediv, found_gpio, entry_total, input ready);
  modport sink (input valid, status, entry_index, found_rate, found_clock, found_prediv,
                found_old_prediv, found_gpio, entry_total, output ready);
endinterface

// ===== src/srtn_ctrl.sv =====
// Sequencer of the sorted rate table: insert walk, search walk, result hand-off.
module srtn_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  srtn_pkg::dp_status_t status,
  output srtn_pkg::ctrl_cmd_t  cmd,
  output logic                 idle
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_INS  = 4'b0010,
    S_SRCH = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state, state_next;

  assign idle = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (status.accept) begin
          cmd.load = 1'b1;
          if (status.in_func == srtn_pkg::FUNC_INSERT) begin
            if (status.count_full) begin
              cmd.res_full = 1'b1;
              state_next   = S_FIN;
            end else begin
              state_next = S_INS;
            end
          end else if (status.count_zero) begin
            cmd.res_empty = 1'b1;
            state_next    = S_FIN;
          end else begin
            state_next = S_SRCH;
          end
        end
      end
      S_INS: begin
        // move lower-rate entries down until the slot is found
        if (status.ptr_zero || !status.rate_gt) begin
          cmd.ins_put = 1'b1;
          state_next  = S_FIN;
        end else begin
          cmd.ins_shift = 1'b1;
        end
      end
      S_SRCH: begin
        if (!status.ptr_zero && status.rate_ge_mid) begin
          cmd.hit_prev = 1'b1;
          state_next   = S_FIN;
        end else if (status.ptr_last) begin
          cmd.hit_cur = 1'b1;
          state_next  = S_FIN;
        end else begin
          cmd.srch_adv = 1'b1;
        end
      end
      S_FIN: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== src/srtn_dp.sv =====
// Datapath of the sorted rate table: entry memory, walk pointer, result and output words.
`include "sorted_rate_table_nearest_unit_macros.svh"

module srtn_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  srtn_pkg::ctrl_cmd_t  cmd,
  input  logic                 idle,
  output srtn_pkg::dp_status_t status,
  srtn_req_if.sink             req,
  srtn_rsp_if.source           rsp
);

  srtn_pkg::entry_t mem [srtn_pkg::DEPTH];
  srtn_pkg::entry_t rd;
  srtn_pkg::entry_t prev;
  srtn_pkg::entry_t item;
  srtn_pkg::result_t res;
  srtn_pkg::result_t out_word;
  logic out_valid;

  logic [srtn_pkg::CNT_W-1:0] count;
  logic [srtn_pkg::CNT_W-1:0] count_inc;
  logic [srtn_pkg::CNT_W-1:0] ptr;
  logic [srtn_pkg::CNT_W-1:0] rd_addr_full;
  logic [srtn_pkg::IDX_W-1:0] rd_addr;
  logic [srtn_pkg::RATE_W:0]  mid_sum;
  logic                       accept;

  // hold ready low through reset so no word is taken and lost
  assign req.ready = idle && !rst;
  assign accept    = req.valid && idle && !rst;
  assign count_inc = count + 1'b1;
  assign mid_sum   = {1'b0, prev.rate} + {1'b0, rd.rate};

  always_comb begin
    rd_addr_full = '0;
    if (cmd.load) begin
      if (req.func == srtn_pkg::FUNC_INSERT && count != '0) begin
        rd_addr_full = count - 1'b1;
      end
    end else if (cmd.ins_shift) begin
      if (ptr > 2'd1) begin
        rd_addr_full = ptr - 2'd2;
      end
    end else if (cmd.srch_adv) begin
      rd_addr_full = ptr + 1'b1;
    end
  end
  assign rd_addr = rd_addr_full[srtn_pkg::IDX_W-1:0];

  assign status.accept      = accept;
  assign status.in_func     = req.func;
  assign status.count_zero  = (count == '0);
  assign status.count_full  = (count == srtn_pkg::CNT_W'(srtn_pkg::DEPTH));
  assign status.ptr_zero    = (ptr == '0);
  assign status.ptr_last    = (ptr == count - 1'b1);
  assign status.rate_gt     = (item.rate > rd.rate);
  assign status.rate_ge_mid = (item.rate >= mid_sum[srtn_pkg::RATE_W:1]);
  assign status.out_free    = !out_valid || rsp.ready;

  // entry memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.ins_shift) begin
      mem[ptr[srtn_pkg::IDX_W-1:0]] <= rd;
    end else if (cmd.ins_put) begin
      mem[ptr[srtn_pkg::IDX_W-1:0]] <= item;
    end
    rd <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item.rate       <= req.rate_hz;
      item.clock      <= req.clock_source;
      item.prediv     <= req.predivider;
      item.old_prediv <= req.old_predivider;
      item.gpio       <= req.gpio_value;
      ptr             <= (req.func == srtn_pkg::FUNC_SEARCH) ? '0 : count;
    end else if (cmd.ins_shift) begin
      ptr <= ptr - 1'b1;
    end else if (cmd.srch_adv) begin
      ptr <= ptr + 1'b1;
    end
    if (cmd.srch_adv) begin
      prev <= rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.ins_put) begin
      count <= count_inc;
    end
  end

  // stage the result word
  always_ff @(posedge clk) begin
    if (cmd.res_full || cmd.res_empty) begin
      res.status <= cmd.res_full ? srtn_pkg::ST_FULL : srtn_pkg::ST_EMPTY;
      res.idx    <= '0;
      res.entry  <= '0;
      res.total  <= srtn_pkg::OUT_TOT_W'(count);
    end else if (cmd.ins_put) begin
      res.status <= srtn_pkg::ST_OK;
      res.idx    <= srtn_pkg::OUT_IDX_W'(ptr);
      res.entry  <= '0;
      res.total  <= srtn_pkg::OUT_TOT_W'(count_inc);
    end else if (cmd.hit_prev) begin
      res.status <= srtn_pkg::ST_OK;
      res.idx    <= srtn_pkg::OUT_IDX_W'(ptr - 1'b1);
      res.entry  <= prev;
      res.total  <= srtn_pkg::OUT_TOT_W'(count);
    end else if (cmd.hit_cur) begin
      res.status <= srtn_pkg::ST_OK;
      res.idx    <= srtn_pkg::OUT_IDX_W'(ptr);
      res.entry  <= rd;
      res.total  <= srtn_pkg::OUT_TOT_W'(count);
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit) begin
      out_word <= res;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.status           = out_word.status;
  assign rsp.entry_index      = out_word.idx;
  assign rsp.found_rate       = out_word.entry.rate;
  assign rsp.found_clock      = out_word.entry.clock;
  assign rsp.found_prediv     = out_word.entry.prediv;
  assign rsp.found_old_prediv = out_word.entry.old_prediv;
  assign rsp.found_gpio       = out_word.entry.gpio;
  assign rsp.entry_total      = out_word.total;

  `SRTN_CHECK_NEXT(a_count_step, cmd.ins_put, count == $past(count_inc))
  `SRTN_CHECK(a_shift_in_range, cmd.ins_shift, !status.ptr_zero && !status.count_full)
  `SRTN_CHECK(a_full_only_when_full, cmd.res_full, status.count_full)
  `SRTN_CHECK_NEXT(a_emit_shows, cmd.emit, out_valid)

endmodule

// ===== src/sorted_rate_table_nearest_unit.sv =====
// Sorted rate table with nearest-rate search: one request word in, one result word out.
// Insert: accept, shift-and-place walk, hand-off; when full: accept, then hand-off.
// Search: accept, a walk over up to entry_count entries, then hand-off.
// The walk reads one entry per cycle from the single-read-port entry memory.
// One request in flight; a new one is taken while the last result word waits.
// Synchronous reset empties the table, drops any pending result word and holds ready low.
module sorted_rate_table_nearest_unit (
  input  logic       clk,
  input  logic       rst,
  srtn_req_if.sink   req,
  srtn_rsp_if.source rsp
);

  srtn_pkg::ctrl_cmd_t  cmd;
  srtn_pkg::dp_status_t status;
  logic                 idle;

  // Sequencer: decides full/empty at accept, then walks the table.
  // Insert walks from the tail up, moving each lower-rate entry down one slot,
  // and drops the new entry where the walk stops. Search walks from the head,
  // comparing the wanted rate to the midpoint of each neighbor pair.
  srtn_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd),
    .idle   (idle)
  );

  // Datapath: entry memory, walk pointer, previous-entry hold, result staging
  // and the output word register that frees the sequencer while a word waits.
  srtn_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .idle   (idle),
    .status (status),
    .req    (req),
    .rsp    (rsp)
  );

endmodule
